@@ hw/rtl/psbp_pkg.sv @@
// ----------------------------------------------------------------------------
// Packet sequence block placer package
// Widths, codes, configuration and result types shared by the placer files.
// ----------------------------------------------------------------------------
package psbp_pkg;

    localparam int SEQ_BITS       = 48;
    localparam int SLOT_BITS      = 16;
    localparam int CFG_BITS       = 17;
    localparam int CFG_INDEX_BITS = 1;
    localparam int CNT_BITS       = 32;
    localparam int IDLE_BITS      = 17;
    localparam int MODE_BITS      = 2;
    localparam int BLK_BITS       = SLOT_BITS + 1;
    localparam int CMP_BITS       = (SEQ_BITS > BLK_BITS) ? SEQ_BITS : BLK_BITS;

    typedef logic [SEQ_BITS-1:0]       seq_t;
    typedef logic [SLOT_BITS-1:0]      slot_t;
    typedef logic [BLK_BITS-1:0]       blk_t;
    typedef logic [CFG_BITS-1:0]       cfg_data_t;
    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
    typedef logic [CNT_BITS-1:0]       cnt_t;
    typedef logic [IDLE_BITS-1:0]      idle_t;
    typedef logic [MODE_BITS-1:0]      mode_t;

    localparam idle_t       IDLE_MAX  = '1;
    localparam logic [31:0] BLOCK_MAX = 32'd1 << SLOT_BITS;

    localparam cfg_index_t REG_BLOCK_PACKETS = CFG_INDEX_BITS'(0);
    localparam cfg_index_t REG_TIMEOUT_LIMIT = CFG_INDEX_BITS'(1);

    localparam cfg_data_t RESET_BLOCK_PACKETS = CFG_BITS'(1024);
    localparam cfg_data_t RESET_TIMEOUT_LIMIT = CFG_BITS'(100000);

    typedef enum logic [1:0] {
        MODE_GOOD       = 2'd0,
        MODE_WRONG_SIZE = 2'd1,
        MODE_IDLE       = 2'd2
    } mode_e;

    typedef enum logic [1:0] {
        DROP_NONE   = 2'd0,
        DROP_LATE   = 2'd1,
        DROP_FUTURE = 2'd2
    } drop_e;

    typedef enum logic [1:0] {
        CLOSE_LAST_SLOT    = 2'd0,
        CLOSE_LATER_PACKET = 2'd1,
        CLOSE_TIMEOUT      = 2'd2
    } close_e;

    typedef struct packed {
        blk_t      block_packets;
        cfg_data_t timeout_limit;
    } cfg_t;

    typedef struct packed {
        logic   write_valid;
        slot_t  slot_index;
        drop_e  drop_kind;
        logic   block_done;
        close_e close_kind;
        cnt_t   packets_received;
        cnt_t   packets_dropped;
    } result_t;

    // Block size as used by the datapath: at least one slot, at most 2^SLOT_BITS.
    function automatic blk_t eff_block(cfg_data_t value);
        logic [31:0] b;
        b = 32'(value);
        if (b == 32'd0)
        begin
            b = 32'd1;
        end
        else if (b > BLOCK_MAX)
        begin
            b = BLOCK_MAX;
        end
        return BLK_BITS'(b);
    endfunction

    localparam blk_t RESET_BLOCK = eff_block(RESET_BLOCK_PACKETS);

endpackage

@@ hw/rtl/psbp_in_if.sv @@
// ----------------------------------------------------------------------------
// Packet sequence block placer input channel
// Valid/ready channel carrying one packet header decision request.
// ----------------------------------------------------------------------------
interface psbp_in_if;
    logic            valid;
    logic            ready;
    psbp_pkg::mode_t mode;
    psbp_pkg::seq_t  seq_number;

    modport source (output valid, output mode, output seq_number, input ready);
    modport sink   (input valid, input mode, input seq_number, output ready);
endinterface

@@ hw/rtl/psbp_out_if.sv @@
// ----------------------------------------------------------------------------
// Packet sequence block placer result channel
// Valid/ready channel carrying the placement decision and running counts.
// ----------------------------------------------------------------------------
interface psbp_out_if;
    logic            valid;
    logic            ready;
    logic            write_valid;
    psbp_pkg::slot_t slot_index;
    logic [1:0]      drop_kind;
    logic            block_done;
    logic [1:0]      close_kind;
    psbp_pkg::cnt_t  packets_received;
    psbp_pkg::cnt_t  packets_dropped;

    modport source (output valid, output write_valid, output slot_index, output drop_kind,
                    output block_done, output close_kind, output packets_received,
                    output packets_dropped, input ready);
    modport sink   (input valid, input write_valid, input slot_index, input drop_kind,
                    input block_done, input close_kind, input packets_received,
                    input packets_dropped, output ready);
endinterface

@@ hw/rtl/packet_sequence_block_placer.sv @@
// ----------------------------------------------------------------------------
// Packet sequence block placer
// Places sequence-numbered packets into consecutive buffer block slots.
// ----------------------------------------------------------------------------
// Each item on the input channel is one packet header (good or wrong size)
// or one idle tick. Every accepted transaction yields exactly one result
// transaction: the slot to write, a drop reason, whether the block closes
// and why, and the running placed and dropped packet counts.
// An accepted item sits in the input register while the decision logic
// runs, and its result is loaded into the output register, from which it
// is presented, once that register is free or its result is being taken.
// Throughput is one item per cycle unless the receiver stalls; the window
// and counter state is updated in the same cycle the decision is taken,
// so the next item sees it at once. The output register parts the two
// channels, so input is taken while a finished result still waits. When
// the receiver stalls, one item stays in each register and input ready
// drops until the result is taken.
// Reset clears the window, the counters and both pipeline valid flags and
// loads the default block size and timeout. Configuration writes are taken
// at any edge with cfg_write high and must only happen while idle.
// ----------------------------------------------------------------------------
module packet_sequence_block_placer (
    input  logic                 clk,
    input  logic                 rst_n,
    psbp_in_if.sink              item,
    psbp_out_if.source           result,
    input  logic                 cfg_write,
    input  psbp_pkg::cfg_index_t cfg_index,
    input  psbp_pkg::cfg_data_t  cfg_data
);
    import psbp_pkg::*;

    cfg_t    cfg;
    logic    item_valid_reg;
    mode_t   mode_reg;
    seq_t    seq_reg;
    logic    res_valid_reg;
    result_t res_reg;
    result_t res_next;
    logic    advance;

    assign advance    = item_valid_reg && (!res_valid_reg || result.ready);
    assign item.ready = !item_valid_reg || advance;

    psbp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    psbp_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .mode       (mode_reg),
        .seq_number (seq_reg),
        .cfg        (cfg),
        .res        (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            item_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            mode_reg <= item.mode;
            seq_reg  <= item.seq_number;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid            = res_valid_reg;
    assign result.write_valid      = res_reg.write_valid;
    assign result.slot_index       = res_reg.slot_index;
    assign result.drop_kind        = res_reg.drop_kind;
    assign result.block_done       = res_reg.block_done;
    assign result.close_kind       = res_reg.close_kind;
    assign result.packets_received = res_reg.packets_received;
    assign result.packets_dropped  = res_reg.packets_dropped;

endmodule

@@ hw/rtl/psbp_cfg.sv @@
// ----------------------------------------------------------------------------
// Packet sequence block placer configuration registers
// Holds the clamped block size and the idle timeout limit.
// ----------------------------------------------------------------------------
module psbp_cfg (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  psbp_pkg::cfg_index_t cfg_index,
    input  psbp_pkg::cfg_data_t  cfg_data,
    output psbp_pkg::cfg_t       cfg
);
    import psbp_pkg::*;

    blk_t      block_reg;
    cfg_data_t timeout_reg;

    // The block size is clamped when written so the datapath never sees it raw.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_reg   <= RESET_BLOCK;
            timeout_reg <= RESET_TIMEOUT_LIMIT;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_BLOCK_PACKETS: block_reg   <= eff_block(cfg_data);
                REG_TIMEOUT_LIMIT: timeout_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    assign cfg = '{block_packets: block_reg, timeout_limit: timeout_reg};

endmodule

@@ hw/rtl/psbp_engine.sv @@
// ----------------------------------------------------------------------------
// Packet sequence block placer decision engine
// Window state, slot placement, drop and block close decisions, counters.
// ----------------------------------------------------------------------------
module psbp_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  psbp_pkg::mode_t   mode,
    input  psbp_pkg::seq_t    seq_number,
    input  psbp_pkg::cfg_t    cfg,
    output psbp_pkg::result_t res
);
    import psbp_pkg::*;

    logic  started_reg,  started_next;
    seq_t  window_reg,   window_next;
    idle_t idle_reg,     idle_next;
    cnt_t  received_reg, received_next;
    cnt_t  dropped_reg,  dropped_next;

    seq_t                win;
    seq_t                diff;
    logic [CMP_BITS-1:0] diff_w;
    logic [CMP_BITS-1:0] blk_w;
    logic                late;
    logic                in_window;
    logic                last;
    logic                advance;

    always_comb
    begin
        // The first good packet anchors the window at its own sequence number.
        win       = started_reg ? window_reg : seq_number;
        late      = seq_number < win;
        diff      = seq_number - win;
        diff_w    = CMP_BITS'(diff);
        blk_w     = CMP_BITS'(cfg.block_packets);
        in_window = diff_w < blk_w;
        last      = diff_w == (blk_w - CMP_BITS'(1));

        started_next  = started_reg;
        window_next   = window_reg;
        idle_next     = idle_reg;
        received_next = received_reg;
        dropped_next  = dropped_reg;
        advance       = 1'b0;

        res.write_valid = 1'b0;
        res.slot_index  = '0;
        res.drop_kind   = DROP_NONE;
        res.block_done  = 1'b0;
        res.close_kind  = CLOSE_LAST_SLOT;

        case (mode)
            MODE_GOOD:
            begin
                idle_next    = '0;
                started_next = 1'b1;
                window_next  = win;
                if (late)
                begin
                    res.drop_kind = DROP_LATE;
                    dropped_next  = dropped_reg + 1'b1;
                end
                else if (in_window)
                begin
                    res.write_valid = 1'b1;
                    res.slot_index  = SLOT_BITS'(diff);
                    received_next   = received_reg + 1'b1;
                    if (last)
                    begin
                        res.block_done = 1'b1;
                        res.close_kind = CLOSE_LAST_SLOT;
                        advance        = 1'b1;
                    end
                end
                else
                begin
                    res.drop_kind  = DROP_FUTURE;
                    dropped_next   = dropped_reg + 1'b1;
                    res.block_done = 1'b1;
                    res.close_kind = CLOSE_LATER_PACKET;
                    advance        = 1'b1;
                end
            end
            MODE_IDLE:
            begin
                if (started_reg)
                begin
                    // The tick that makes the count exceed the limit closes the block.
                    if (idle_reg >= cfg.timeout_limit)
                    begin
                        res.block_done = 1'b1;
                        res.close_kind = CLOSE_TIMEOUT;
                        idle_next      = '0;
                        advance        = 1'b1;
                    end
                    else
                    begin
                        idle_next = idle_reg + 1'b1;
                    end
                end
                else if (idle_reg != IDLE_MAX)
                begin
                    idle_next = idle_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        if (advance)
        begin
            window_next = win + SEQ_BITS'(cfg.block_packets);
        end

        res.packets_received = received_next;
        res.packets_dropped  = dropped_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg  <= 1'b0;
            window_reg   <= '0;
            idle_reg     <= '0;
            received_reg <= '0;
            dropped_reg  <= '0;
        end
        else if (step)
        begin
            started_reg  <= started_next;
            window_reg   <= window_next;
            idle_reg     <= idle_next;
            received_reg <= received_next;
            dropped_reg  <= dropped_next;
        end
    end

endmodule

@@ hw/rtl/psbp_checker.sv @@
// ----------------------------------------------------------------------------
// Packet sequence block placer port checker
// Watches the top-level ports for inconsistent results over time.
// ----------------------------------------------------------------------------
module psbp_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            result_valid,
    input logic            result_ready,
    input logic            write_valid,
    input psbp_pkg::slot_t slot_index,
    input logic [1:0]      drop_kind,
    input logic            block_done,
    input logic [1:0]      close_kind,
    input psbp_pkg::cnt_t  packets_received,
    input psbp_pkg::cnt_t  packets_dropped
);
    import psbp_pkg::*;

    // A stalled result transaction keeps its counts.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(packets_received)
            && $stable(packets_dropped))
    else $error("stalled result changed");

    // A placed packet is never also dropped, and an unplaced one reports slot zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (write_valid ? (drop_kind == DROP_NONE) : (slot_index == '0)))
    else $error("placement and drop disagree");

    // A packet beyond the window always closes the block as a later-packet close.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (drop_kind == DROP_FUTURE)
            |-> block_done && (close_kind == CLOSE_LATER_PACKET))
    else $error("future drop without block close");

    // Back-to-back results advance the combined packet count by at most one.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready ##1 result_valid
            |-> (32'(packets_received - $past(packets_received))
                 + 32'(packets_dropped - $past(packets_dropped))) <= 32'd1)
    else $error("packet counts jumped");

endmodule

bind packet_sequence_block_placer psbp_checker u_psbp_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .result_valid     (result.valid),
    .result_ready     (result.ready),
    .write_valid      (result.write_valid),
    .slot_index       (result.slot_index),
    .drop_kind        (result.drop_kind),
    .block_done       (result.block_done),
    .close_kind       (result.close_kind),
    .packets_received (result.packets_received),
    .packets_dropped  (result.packets_dropped)
);

@@ tb/sv/packet_sequence_block_placer_tb.sv @@
// ----------------------------------------------------------------------------
// Packet sequence block placer testbench
// Drives packet headers, wrong-size packets and idle ticks through the input
// channel under several block sizes and timeout limits. A behavioral copy of
// the placement window predicts every result transaction, and the monitor
// compares each result field by field in order while both sides stall.
// ----------------------------------------------------------------------------
module packet_sequence_block_placer_tb;
    import psbp_pkg::*;

    localparam mode_t MODE_UNUSED    = 2'd3;
    localparam int    RESULT_LATENCY = 2;
    localparam int    SETTLE_CYCLES  = RESULT_LATENCY + 4;
    localparam seq_t  FIRST_SEQ      = ~seq_t'(1025);
    localparam int    PHASE_COUNT    = 8;
    localparam int    PHASE_ITEMS    = 100;

    typedef struct packed {
        mode_t mode;
        seq_t  seq;
    } header_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_write;
    cfg_index_t cfg_index;
    cfg_data_t  cfg_data;

    psbp_in_if  item_ch ();
    psbp_out_if result_ch ();

    packet_sequence_block_placer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predicted placer state and configuration.
    cfg_data_t cfg_blocks   = RESET_BLOCK_PACKETS;
    cfg_data_t cfg_timeout  = RESET_TIMEOUT_LIMIT;
    logic      anchored     = 1'b0;
    seq_t      win_start    = '0;
    idle_t     idle_run     = '0;
    cnt_t      placed_count = '0;
    cnt_t      dropped_total = '0;

    header_t headers_to_send[$];
    result_t placements_due[$];
    int      mismatches = 0;
    bit      idling     = 1'b1;
    int      send_gap   = 0;
    int      take_gap   = 0;
    header_t next_header;
    result_t due;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("FAIL packet_sequence_block_placer");
        $finish;
    end

    function automatic blk_t slots_per_block();
        if (cfg_blocks == '0)
        begin
            return blk_t'(1);
        end
        if (32'(cfg_blocks) > (32'd1 << SLOT_BITS))
        begin
            return blk_t'(32'd1 << SLOT_BITS);
        end
        return blk_t'(cfg_blocks);
    endfunction

    function automatic result_t place_packet(mode_t m, seq_t s);
        result_t             r;
        blk_t                nb;
        seq_t                offset;
        logic [IDLE_BITS:0]  ticks;
        r            = '0;
        r.drop_kind  = DROP_NONE;
        r.close_kind = CLOSE_LAST_SLOT;
        nb           = slots_per_block();
        if (m == MODE_GOOD)
        begin
            idle_run = '0;
            if (!anchored)
            begin
                win_start = s;
                anchored  = 1'b1;
            end
            if (s < win_start)
            begin
                r.drop_kind   = DROP_LATE;
                dropped_total = dropped_total + 1;
            end
            else
            begin
                offset = s - win_start;
                if (offset < seq_t'(nb))
                begin
                    r.write_valid = 1'b1;
                    r.slot_index  = slot_t'(offset);
                    placed_count  = placed_count + 1;
                    if (offset == seq_t'(nb) - 1)
                    begin
                        r.block_done = 1'b1;
                        win_start    = win_start + seq_t'(nb);
                    end
                end
                else
                begin
                    r.drop_kind   = DROP_FUTURE;
                    r.block_done  = 1'b1;
                    r.close_kind  = CLOSE_LATER_PACKET;
                    dropped_total = dropped_total + 1;
                    win_start     = win_start + seq_t'(nb);
                end
            end
        end
        else if (m == MODE_IDLE)
        begin
            if (anchored)
            begin
                ticks = {1'b0, idle_run} + 1'b1;
                if (ticks > {1'b0, cfg_timeout})
                begin
                    r.block_done = 1'b1;
                    r.close_kind = CLOSE_TIMEOUT;
                    idle_run     = '0;
                    win_start    = win_start + seq_t'(nb);
                end
                else
                begin
                    idle_run = idle_t'(ticks);
                end
            end
            else if (idle_run != IDLE_MAX)
            begin
                // Before the first good packet the idle count only saturates.
                idle_run = idle_run + 1'b1;
            end
        end
        r.packets_received = placed_count;
        r.packets_dropped  = dropped_total;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (!idling)
        begin
            return 0;
        end
        r = $urandom_range(99);
        if (r < 65)
        begin
            return 0;
        end
        if (r < 95)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic seq_t random_seq();
        return seq_t'({$urandom, $urandom});
    endfunction

    task automatic report_mismatch(string msg);
        $display("ERROR %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
        end
    endtask

    // Driver: presents queued headers and predicts each accepted transaction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_ch.valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (item_ch.valid && item_ch.ready)
            begin
                placements_due.push_back(place_packet(item_ch.mode, item_ch.seq_number));
                send_gap = pick_gap();
            end
            if (item_ch.valid && !item_ch.ready)
            begin
                // Hold the transaction until it is taken.
            end
            else if (send_gap > 0)
            begin
                send_gap--;
                item_ch.valid <= 1'b0;
            end
            else if (headers_to_send.size() > 0)
            begin
                next_header = headers_to_send.pop_front();
                item_ch.valid      <= 1'b1;
                item_ch.mode       <= next_header.mode;
                item_ch.seq_number <= next_header.seq;
            end
            else
            begin
                item_ch.valid <= 1'b0;
            end
        end
    end

    // Monitor: stalls the result channel and checks every result transaction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            take_gap = 0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (placements_due.size() == 0)
                begin
                    report_mismatch("result transaction with no prediction waiting");
                end
                else
                begin
                    due = placements_due.pop_front();
                    check_field("write_valid", result_ch.write_valid, due.write_valid);
                    check_field("slot_index", result_ch.slot_index, due.slot_index);
                    check_field("drop_kind", result_ch.drop_kind, due.drop_kind);
                    check_field("block_done", result_ch.block_done, due.block_done);
                    check_field("close_kind", result_ch.close_kind, due.close_kind);
                    check_field("packets_received", result_ch.packets_received,
                                due.packets_received);
                    check_field("packets_dropped", result_ch.packets_dropped,
                                due.packets_dropped);
                end
                take_gap = pick_gap();
            end
            if (take_gap > 0)
            begin
                take_gap--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    task automatic queue_header(mode_t m, seq_t s);
        header_t h;
        h.mode = m;
        h.seq  = s;
        headers_to_send.push_back(h);
    endtask

    task automatic wait_drain();
        do
        begin
            @(negedge clk);
        end
        while (headers_to_send.size() != 0 || item_ch.valid || placements_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Only called while the placer is idle.
    task automatic set_config(cfg_data_t blocks, cfg_data_t limit);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= REG_BLOCK_PACKETS;
        cfg_data  <= blocks;
        @(posedge clk);
        cfg_index <= REG_TIMEOUT_LIMIT;
        cfg_data  <= limit;
        @(posedge clk);
        cfg_write <= 1'b0;
        cfg_blocks  = blocks;
        cfg_timeout = limit;
    endtask

    // Mostly packets aimed at the current window, with idle bursts long
    // enough to reach small timeout limits, late and future packets, and noise.
    task automatic random_headers(int count);
        int   made;
        int   r;
        int   burst_cap;
        blk_t nb;
        seq_t offset;
        made = 0;
        while (made < count)
        begin
            do
            begin
                @(negedge clk);
            end
            while (headers_to_send.size() != 0);
            nb = slots_per_block();
            r  = $urandom_range(99);
            if (r < 8)
            begin
                if ($urandom_range(1) == 0)
                begin
                    queue_header(MODE_WRONG_SIZE, random_seq());
                end
                else
                begin
                    queue_header(MODE_UNUSED, random_seq());
                end
            end
            else if (r < 22)
            begin
                burst_cap = (cfg_timeout < 22) ? int'(cfg_timeout) + 2 : 24;
                repeat ($urandom_range(1, burst_cap))
                begin
                    queue_header(MODE_IDLE, random_seq());
                    made++;
                end
            end
            else
            begin
                if (r < 70)
                begin
                    if ($urandom_range(2) == 0)
                    begin
                        offset = seq_t'(nb) - 1;
                    end
                    else
                    begin
                        offset = seq_t'($urandom_range(int'(nb) - 1));
                    end
                    queue_header(MODE_GOOD, win_start + offset);
                end
                else if (r < 80)
                begin
                    queue_header(MODE_GOOD, win_start - seq_t'($urandom_range(1, 64)));
                end
                else if (r < 90)
                begin
                    queue_header(MODE_GOOD,
                                 win_start + seq_t'(nb) + seq_t'($urandom_range(1000)));
                end
                else
                begin
                    queue_header(MODE_GOOD, random_seq());
                end
                made++;
            end
            if ($urandom_range(79) == 0)
            begin
                wait_drain();
            end
        end
    endtask

    initial
    begin
        cfg_data_t phase_blocks[PHASE_COUNT];
        cfg_data_t phase_limits[PHASE_COUNT];
        phase_blocks = '{4, 1, 65536, 0, 7, 1024, 131071, 2};
        phase_limits = '{2, 1, 131071, 0, 5, 100000, 3, 9};

        rst_n              = 1'b0;
        cfg_write          = 1'b0;
        cfg_index          = REG_BLOCK_PACKETS;
        cfg_data           = '0;
        item_ch.valid      = 1'b0;
        item_ch.mode       = MODE_IDLE;
        item_ch.seq_number = '0;
        result_ch.ready    = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Idle, wrong-size and unused-mode items before capture starts, then
        // the anchoring packet just below the top of the sequence space.
        queue_header(MODE_IDLE, '1);
        queue_header(MODE_WRONG_SIZE, '0);
        queue_header(MODE_UNUSED, '1);
        queue_header(MODE_IDLE, '0);
        queue_header(MODE_GOOD, FIRST_SEQ);
        queue_header(MODE_GOOD, FIRST_SEQ + 1023);
        queue_header(MODE_GOOD, '1);
        queue_header(MODE_GOOD, '0);
        queue_header(MODE_IDLE, '0);
        queue_header(MODE_IDLE, '1);
        wait_drain();

        // Block size zero acts as one slot; a zero limit times out every tick.
        // The window wraps past zero here.
        set_config(0, 0);
        queue_header(MODE_IDLE, '0);
        queue_header(MODE_GOOD, '1);
        queue_header(MODE_GOOD, '0);
        queue_header(MODE_GOOD, '0);
        queue_header(MODE_GOOD, 5);
        queue_header(MODE_WRONG_SIZE, '1);
        queue_header(MODE_UNUSED, '0);
        wait_drain();

        // Oversized block clamps to the largest slot count.
        set_config(131071, 3);
        queue_header(MODE_GOOD, 65537);
        queue_header(MODE_GOOD, 65538 + 70000);
        queue_header(MODE_GOOD, 131074 + 21845);
        repeat (3) queue_header(MODE_IDLE, '0);
        queue_header(MODE_WRONG_SIZE, '0);
        queue_header(MODE_IDLE, '0);
        repeat (2) queue_header(MODE_IDLE, '0);
        queue_header(MODE_GOOD, 196610 + 5);
        repeat (4) queue_header(MODE_IDLE, '0);
        wait_drain();

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            idling = (p % 3 != 1);
            set_config(phase_blocks[p], phase_limits[p]);
            random_headers(PHASE_ITEMS);
            wait_drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && placements_due.size() == 0)
        begin
            $display("PASS packet_sequence_block_placer");
        end
        else
        begin
            $display("FAIL packet_sequence_block_placer");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/psbp_pkg.sv
hw/rtl/psbp_in_if.sv
hw/rtl/psbp_out_if.sv
hw/rtl/psbp_cfg.sv
hw/rtl/psbp_engine.sv
hw/rtl/packet_sequence_block_placer.sv
hw/rtl/psbp_checker.sv
tb/sv/packet_sequence_block_placer_tb.sv
